// ===== rtl/multichannel_dynamic_range_compressor_top_defines.svh =====
// Assertion macros used by the compressor top module.
// They expect clk_i and rst_ni in the scope of use.
`ifndef MULTICHANNEL_DYNAMIC_RANGE_COMPRESSOR_TOP_DEFINES_SVH
`define MULTICHANNEL_DYNAMIC_RANGE_COMPRESSOR_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define MDRC_ASSERT_IMPL(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("mdrc assertion failed");

// Condition holds in the cycle after the trigger.
`define MDRC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("mdrc assertion failed");

`endif

// ===== rtl/mdrc_pkg.sv =====
package mdrc_pkg;

  // Default number of channels.
  localparam int unsigned CHANNELS_DEF = 128;

  // Widths of the stream payloads.
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned COEF_W     = 80;
  localparam int unsigned LEVEL_W    = 15;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_PROCESS = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LEVEL_OFFSET   = 3'd0,
    CFG_ATTACK_COEF    = 3'd1,
    CFG_RELEASE_COEF   = 3'd2,
    CFG_KNEE_LOW       = 3'd3,
    CFG_KNEE_HIGH      = 3'd4,
    CFG_OUTPUT_CEILING = 3'd5
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [15:0] LEVEL_OFFSET_RST   = 16'd0;
  localparam logic [15:0] ATTACK_COEF_RST    = 16'd32768;
  localparam logic [15:0] RELEASE_COEF_RST   = 16'd62259;
  localparam logic [14:0] KNEE_LOW_RST       = 15'd10240;
  localparam logic [14:0] KNEE_HIGH_RST      = 15'd16640;
  localparam logic [14:0] OUTPUT_CEILING_RST = 15'd30720;

  // 10*log10(2) in Q16 and log2(10)/20 in Q24, scaled so that dB Q8.8 maps to log2 Q32.
  localparam logic [17:0] LOG_SCALE = 18'd197283;
  localparam logic signed [22:0] GAIN_SCALE = 23'sd2786635;

  // Roots 2^(2^-k) in Q30 for k = 1..16, each the truncated square root of the one before.
  typedef logic [15:0][30:0] root_tab_t;

  function automatic root_tab_t exp_root_table();
    root_tab_t   tab;
    logic [63:0] root;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bm;
    root = 64'd1 << 31;
    for (int k = 0; k < 16; k++) begin
      v  = root << 30;
      r  = 64'd0;
      bm = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (v >= r + bm) begin
          v = v - (r + bm);
          r = (r >> 1) + bm;
        end else begin
          r = r >> 1;
        end
        bm = bm >> 2;
      end
      root   = r;
      tab[k] = root[30:0];
    end
    return tab;
  endfunction

endpackage

// ===== rtl/multichannel_dynamic_range_compressor_top.sv =====
// Multichannel three-segment compressor. A process transaction carries one channel's
// linear power; the block converts it to dB, smooths it against the channel's stored
// level, maps it through the channel's three-segment curve and returns the level and
// a Q16.16 linear gain. A load transaction writes one channel's curve coefficients in
// the cycle it is accepted and returns nothing, and the next transaction can be taken
// in the following cycle. One item is worked on at a time. A process transaction
// passes through the log unit (normalise, 16 squarings, scale), smoothing, curve and
// gain scaling, the gain unit (16 root multiplications and the shift) and the output
// register before the next transaction can be accepted. When the gain saturates, the
// gain unit answers at once. While an earlier result still waits in the output
// register, the sequencer holds in its last state until that result is taken.
// After reset every entry of the level memory is swept to zero before the first item
// is accepted.
`include "multichannel_dynamic_range_compressor_top_defines.svh"

module multichannel_dynamic_range_compressor_top
  import mdrc_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: channel[6:0], power[38:7], low_offset[54:39], mid_slope[70:55],
  // mid_offset[86:71], high_slope[102:87], high_offset[118:103], zero[119]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation[0]
  input  logic [0:0]            s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: out_channel[6:0], smoothed_level[21:7], linear_gain[53:22], zero[55:54]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_LOG   = 11'b000_0000_0100,
    ST_SMUL  = 11'b000_0000_1000,
    ST_SSUM  = 11'b000_0001_0000,
    ST_CMUL  = 11'b000_0010_0000,
    ST_CSUM  = 11'b000_0100_0000,
    ST_GMUL  = 11'b000_1000_0000,
    ST_EXPGO = 11'b001_0000_0000,
    ST_EXP   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0]        level_offset_q, attack_coef_q, release_coef_q;
  logic [14:0]        knee_low_q, knee_high_q, output_ceiling_q;

  // Input fields.
  logic [6:0]         in_ch;
  logic [10:0]        in_ch_ext;
  logic [AW-1:0]      in_addr;
  logic               ch_ok;
  logic               in_acc, proc_acc, load_acc;

  // Memories and sequencing.
  logic [AW-1:0]      clr_cnt_q;
  logic               lvl_we;
  logic [AW-1:0]      lvl_waddr;
  logic [LEVEL_W-1:0] lvl_wdata, lvl_rd;
  logic [COEF_W-1:0]  coef_rd;
  logic [6:0]         ch_q;
  logic [10:0]        ch_q_ext;

  // Arithmetic.
  logic               log_done;
  logic [LEVEL_W-1:0] log_level;
  logic signed [17:0] x_q;
  logic               rise;
  logic [15:0]        c_sel;
  logic [16:0]        w_sel;
  logic signed [35:0] prod_a_q;
  logic [30:0]        prod_b_q;
  logic signed [36:0] sum;
  logic signed [36:0] sum_rnd;
  logic [LEVEL_W-1:0] s_d, s_q;
  logic signed [15:0] slope_sel, off_sel;
  logic signed [31:0] prod_c_q;
  logic signed [15:0] off_q;
  logic signed [31:0] prod_c_rnd;
  logic signed [20:0] o_raw, o_cap;
  logic signed [21:0] d_q;
  logic signed [44:0] gprod;
  logic signed [47:0] t_q;
  logic               exp_done;
  logic [31:0]        exp_gain;
  logic               out_valid_q, out_load;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Input decode.
  assign in_ch     = s_axis_tdata[6:0];
  assign in_ch_ext = 11'(in_ch);
  assign in_addr   = in_ch_ext[AW-1:0];
  assign ch_ok     = (in_ch_ext < 11'(CHANNELS));
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign proc_acc  = in_acc && ch_ok && (s_axis_tuser[0] == OP_PROCESS);
  assign load_acc  = in_acc && ch_ok && (s_axis_tuser[0] == OP_LOAD);
  assign ch_q_ext  = 11'(ch_q);

  // Configuration registers, written whenever offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_offset_q   <= LEVEL_OFFSET_RST;
      attack_coef_q    <= ATTACK_COEF_RST;
      release_coef_q   <= RELEASE_COEF_RST;
      knee_low_q       <= KNEE_LOW_RST;
      knee_high_q      <= KNEE_HIGH_RST;
      output_ceiling_q <= OUTPUT_CEILING_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEVEL_OFFSET:   level_offset_q   <= cfg_data_i;
        CFG_ATTACK_COEF:    attack_coef_q    <= cfg_data_i;
        CFG_RELEASE_COEF:   release_coef_q   <= cfg_data_i;
        CFG_KNEE_LOW:       knee_low_q       <= cfg_data_i[14:0];
        CFG_KNEE_HIGH:      knee_high_q      <= cfg_data_i[14:0];
        CFG_OUTPUT_CEILING: output_ceiling_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Level memory: cleared after reset, written back once per process transaction.
  assign lvl_we    = (state_q == ST_CLEAR) || (state_q == ST_SSUM);
  assign lvl_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : ch_q_ext[AW-1:0];
  assign lvl_wdata = (state_q == ST_CLEAR) ? '0 : s_d;

  mdrc_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(CHANNELS)
  ) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (lvl_we),
    .waddr_i(lvl_waddr),
    .wdata_i(lvl_wdata),
    .re_i   (proc_acc),
    .raddr_i(in_addr),
    .rdata_o(lvl_rd)
  );

  mdrc_ram #(
    .WIDTH(COEF_W),
    .DEPTH(CHANNELS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (load_acc),
    .waddr_i(in_addr),
    .wdata_i(s_axis_tdata[118:39]),
    .re_i   (proc_acc),
    .raddr_i(in_addr),
    .rdata_o(coef_rd)
  );

  mdrc_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(proc_acc),
    .power_i(s_axis_tdata[38:7]),
    .done_o (log_done),
    .level_o(log_level)
  );

  // Smoothing: weight selection and the two products.
  assign rise  = x_q > $signed({3'b000, lvl_rd});
  assign c_sel = rise ? attack_coef_q : release_coef_q;
  assign w_sel = 17'h1_0000 - {1'b0, c_sel};

  // Rounded smoothed level, clamped to the valid range.
  assign sum     = 37'(prod_a_q) + $signed({6'b00_0000, prod_b_q});
  assign sum_rnd = sum + 37'sd32768;
  always_comb begin
    if (sum <= 37'sd0) begin
      s_d = '0;
    end else if (|sum_rnd[36:31]) begin
      s_d = 15'h7FFF;
    end else begin
      s_d = sum_rnd[30:16];
    end
  end

  // Segment selection; the low segment is unit slope in Q4.12.
  always_comb begin
    if (s_q < knee_low_q) begin
      slope_sel = 16'sd4096;
      off_sel   = $signed(coef_rd[15:0]);
    end else if (s_q < knee_high_q) begin
      slope_sel = $signed(coef_rd[31:16]);
      off_sel   = $signed(coef_rd[47:32]);
    end else begin
      slope_sel = $signed(coef_rd[63:48]);
      off_sel   = $signed(coef_rd[79:64]);
    end
  end

  // Output level capped at the ceiling.
  assign prod_c_rnd = prod_c_q + 32'sd2048;
  assign o_raw      = 21'(prod_c_rnd >>> 12) + 21'(off_q);
  assign o_cap      = (o_raw > $signed({6'b00_0000, output_ceiling_q})) ?
                      $signed({6'b00_0000, output_ceiling_q}) : o_raw;
  assign gprod      = d_q * GAIN_SCALE;

  mdrc_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_EXPGO),
    .t_i    (t_q),
    .done_o (exp_done),
    .gain_o (exp_gain)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == AW'(CHANNELS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (proc_acc) state_d = ST_LOG;
      ST_LOG:   if (log_done) state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_SSUM;
      ST_SSUM:  state_d = ST_CMUL;
      ST_CMUL:  state_d = ST_CSUM;
      ST_CSUM:  state_d = ST_GMUL;
      ST_GMUL:  state_d = ST_EXPGO;
      ST_EXPGO: state_d = ST_EXP;
      ST_EXP:   if (exp_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (proc_acc) begin
      ch_q <= in_ch;
    end
    if (log_done) begin
      x_q <= $signed({3'b000, log_level}) +
             $signed({{2{level_offset_q[15]}}, level_offset_q});
    end
    if (state_q == ST_SMUL) begin
      prod_a_q <= x_q * $signed({1'b0, w_sel});
      prod_b_q <= c_sel * lvl_rd;
    end
    if (state_q == ST_SSUM) begin
      s_q <= s_d;
    end
    if (state_q == ST_CMUL) begin
      prod_c_q <= slope_sel * $signed({1'b0, s_q});
      off_q    <= off_sel;
    end
    if (state_q == ST_CSUM) begin
      d_q <= 22'(o_cap) - $signed({7'b000_0000, s_q});
    end
    if (state_q == ST_GMUL) begin
      t_q <= 48'(gprod) + (48'sd1 <<< 36);
    end
    if (out_load) begin
      out_data_q <= {2'b00, exp_gain, s_q, ch_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `MDRC_ASSERT_IMPL(a_lvl_write_phase, lvl_we,
                    (state_q == ST_CLEAR) || (state_q == ST_SSUM))
  `MDRC_ASSERT_NEXT(a_proc_starts_log, proc_acc, state_q == ST_LOG)
  `MDRC_ASSERT_IMPL(a_exp_done_phase, exp_done, state_q == ST_EXP)
  `MDRC_ASSERT_IMPL(a_no_overwrite, out_valid_q && !m_axis_tready, !out_load)

endmodule

// ===== rtl/mdrc_ram.sv =====
module mdrc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mdrc_log.sv =====
module mdrc_log
  import mdrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        power_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] level_o
);

  typedef enum logic [3:0] {
    LG_IDLE  = 4'b0001,
    LG_NORM  = 4'b0010,
    LG_SQR   = 4'b0100,
    LG_SCALE = 4'b1000
  } lg_state_e;

  lg_state_e          state_q, state_d;
  logic [31:0]        p_q;
  logic [31:0]        m_q, m_d;
  logic [4:0]         e_q, e_d;
  logic [15:0]        frac_q, frac_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               done_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [4:0]         msb;
  logic [63:0]        sq;
  logic [32:0]        msq;
  logic [38:0]        scaled;

  // Position of the leading one of the captured power.
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (p_q[i]) begin
        msb = 5'(i);
      end
    end
  end

  assign sq     = 64'(m_q) * 64'(m_q);
  assign msq    = sq[63:31];
  assign scaled = 39'({e_q, frac_q}) * 39'(LOG_SCALE) + (39'd1 << 23);

  // One mantissa squaring per cycle gives one fraction bit of log2.
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    e_d     = e_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          state_d = LG_NORM;
        end
      end
      LG_NORM: begin
        e_d     = msb;
        m_d     = 32'(p_q << (5'd31 - msb));
        frac_d  = 16'd0;
        cnt_d   = 4'd15;
        state_d = LG_SQR;
      end
      LG_SQR: begin
        if (msq[32]) begin
          frac_d[cnt_q] = 1'b1;
          m_d           = msq[32:1];
        end else begin
          m_d = msq[31:0];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = LG_SCALE;
        end
      end
      LG_SCALE: begin
        level_d = scaled[38:24];
        state_d = LG_IDLE;
      end
      default: begin
        state_d = LG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == LG_SCALE);
    end
  end

  // Datapath registers; a zero power is taken as one.
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == LG_IDLE) begin
      p_q <= (power_i == 32'd0) ? 32'd1 : power_i;
    end
    m_q     <= m_d;
    e_q     <= e_d;
    frac_q  <= frac_d;
    cnt_q   <= cnt_d;
    level_q <= level_d;
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

// ===== rtl/mdrc_exp.sv =====
module mdrc_exp
  import mdrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] t_i,
  output logic               done_o,
  output logic [31:0]        gain_o
);

  typedef enum logic [2:0] {
    EX_IDLE  = 3'b001,
    EX_RUN   = 3'b010,
    EX_SHIFT = 3'b100
  } ex_state_e;

  localparam root_tab_t ROOT_TAB = exp_root_table();

  ex_state_e   state_q, state_d;
  logic [4:0]  n_q, n_d;
  logic [15:0] f_q, f_d;
  logic [30:0] m_q, m_d;
  logic [3:0]  k_q, k_d;
  logic [31:0] gain_q, gain_d;
  logic        done_q, done_d;
  logic [61:0] prod;
  logic [62:0] shifted;

  assign prod    = 62'(m_q) * 62'(ROOT_TAB[k_q]);
  assign shifted = 63'(m_q) << n_q;

  // One fraction bit per cycle, times its root if set, then the integer shift.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    f_d     = f_q;
    m_d     = m_q;
    k_d     = k_q;
    gain_d  = gain_q;
    done_d  = 1'b0;
    case (state_q)
      EX_IDLE: begin
        if (start_i) begin
          if (t_i[47]) begin
            gain_d = 32'd0;
            done_d = 1'b1;
          end else if (|t_i[46:37]) begin
            gain_d = 32'hFFFF_FFFF;
            done_d = 1'b1;
          end else begin
            n_d     = t_i[36:32];
            f_d     = t_i[31:16];
            m_d     = 31'd1 << 30;
            k_d     = 4'd0;
            state_d = EX_RUN;
          end
        end
      end
      EX_RUN: begin
        if (f_q[4'd15 - k_q]) begin
          m_d = prod[60:30];
        end
        k_d = k_q + 4'd1;
        if (k_q == 4'd15) begin
          state_d = EX_SHIFT;
        end
      end
      EX_SHIFT: begin
        gain_d  = shifted[61:30];
        done_d  = 1'b1;
        state_d = EX_IDLE;
      end
      default: begin
        state_d = EX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EX_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    f_q    <= f_d;
    m_q    <= m_d;
    k_q    <= k_d;
    gain_q <= gain_d;
  end

  assign done_o = done_q;
  assign gain_o = gain_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mdrc_pkg::*;

  localparam int unsigned NUM_CH      = 128;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PER_PHASE   = 200;
  localparam int unsigned SETTLE      = 80;
  localparam longint      CYCLE_LIMIT = 1500000;

  // One input transaction.
  typedef struct {
    op_e         op;
    logic [6:0]  ch;
    logic [31:0] power;
    logic [15:0] lo_off;
    logic [15:0] mid_slope;
    logic [15:0] mid_off;
    logic [15:0] hi_slope;
    logic [15:0] hi_off;
  } bin_item_t;

  // One expected output transaction.
  typedef struct {
    logic [6:0]  ch;
    logic [14:0] level;
    logic [31:0] gain;
  } gain_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i = '0;
  logic [15:0]           cfg_data_i  = '0;

  multichannel_dynamic_range_compressor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow configuration and channel state of the compressor.
  logic [15:0] sh_level_offset   = LEVEL_OFFSET_RST;
  logic [15:0] sh_attack         = ATTACK_COEF_RST;
  logic [15:0] sh_release        = RELEASE_COEF_RST;
  logic [14:0] sh_knee_low       = KNEE_LOW_RST;
  logic [14:0] sh_knee_high      = KNEE_HIGH_RST;
  logic [14:0] sh_ceiling        = OUTPUT_CEILING_RST;
  logic [15:0] sh_level   [NUM_CH];
  logic [15:0] sh_lo_off  [NUM_CH];
  logic [15:0] sh_mslope  [NUM_CH];
  logic [15:0] sh_moff    [NUM_CH];
  logic [15:0] sh_hslope  [NUM_CH];
  logic [15:0] sh_hoff    [NUM_CH];

  bin_item_t    bin_queue[$];
  gain_result_t pending_gains[$];
  int           loaded_chans[$];
  bit           is_loaded[NUM_CH];
  int           mismatches   = 0;
  int           n_process    = 0;
  int           n_load       = 0;
  int           n_results    = 0;
  longint       cycles       = 0;
  bit           quiet_phase  = 0;
  int           send_gap     = 0;
  int           recv_stall   = 0;

  // Integer square root, truncated.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Level of a linear power in dB, Q8.8; zero power counts as one.
  function automatic longint power_db(logic [31:0] p);
    longint unsigned m, frac, lg;
    int e;
    frac = 0;
    if (p == 0) p = 32'd1;
    e = 31;
    while (p[e] == 1'b0) e--;
    m = longint'(p) << (31 - e);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        frac = frac | (64'd1 << i);
        m = m >> 1;
      end
    end
    lg = (longint'(e) << 16) | frac;
    return longint'((lg * 197283 + (64'd1 << 23)) >> 24);
  endfunction

  // Linear gain in Q16.16 for a dB difference in Q8.8, saturating.
  function automatic logic [31:0] db_gain(longint d);
    longint          t;
    longint unsigned root, m, f, w;
    int              n;
    t = d * 2786635 + (64'sd16 <<< 32);
    if (t >= (64'sd32 <<< 32)) return 32'hFFFF_FFFF;
    if (t < 0) return 32'd0;
    n = int'(t >>> 32);
    f = t & 64'hFFFF_FFFF;
    root = 64'd1 << 31;
    m = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      root = int_sqrt(root << 30);
      if (f[32-k]) m = (m * root) >> 30;
    end
    w = (m << n) >> 30;
    return w[31:0];
  endfunction

  // Applies one accepted transaction to the shadow state; queues any result.
  function automatic void compress_bin(bin_item_t it);
    longint x, stored, c, sum, s, o;
    gain_result_t r;
    if (it.op == OP_LOAD) begin
      sh_lo_off[it.ch] = it.lo_off;
      sh_mslope[it.ch] = it.mid_slope;
      sh_moff[it.ch]   = it.mid_off;
      sh_hslope[it.ch] = it.hi_slope;
      sh_hoff[it.ch]   = it.hi_off;
      return;
    end
    x = power_db(it.power) + longint'($signed(sh_level_offset));
    stored = longint'(sh_level[it.ch]);
    c = (x > stored) ? longint'(sh_attack) : longint'(sh_release);
    sum = (65536 - c) * x + c * stored;
    if (sum <= 0) begin
      s = 0;
    end else begin
      s = (sum + 32768) >>> 16;
      if (s > 32767) s = 32767;
    end
    sh_level[it.ch] = s[15:0];
    if (s < longint'(sh_knee_low))
      o = s + longint'($signed(sh_lo_off[it.ch]));
    else if (s < longint'(sh_knee_high))
      o = ((longint'($signed(sh_mslope[it.ch])) * s + 2048) >>> 12)
          + longint'($signed(sh_moff[it.ch]));
    else
      o = ((longint'($signed(sh_hslope[it.ch])) * s + 2048) >>> 12)
          + longint'($signed(sh_hoff[it.ch]));
    if (o > longint'(sh_ceiling)) o = longint'(sh_ceiling);
    r.ch    = it.ch;
    r.level = s[14:0];
    r.gain  = db_gain(o - s);
    pending_gains.push_back(r);
  endfunction

  // Mostly short gaps, now and then a long one; none in a quiet phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("ERROR: %s got 0x%0h expected 0x%0h at cycle %0d", field, got, want, cycles);
  endtask

  // Driver: presents queued transactions with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    bin_item_t it;
    logic      next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        compress_bin(bin_queue.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (bin_queue.size() > 0) begin
          it = bin_queue[0];
          s_axis_tdata <= {1'b0, it.hi_off, it.hi_slope, it.mid_off, it.mid_slope,
                           it.lo_off, it.power, it.ch};
          s_axis_tuser <= it.op;
          next_valid = 1'b1;
          send_gap <= pick_gap();
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Monitor: stalls at random and checks each result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    gain_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pending_gains.size() == 0) begin
          report_mismatch("unexpected result", longint'(m_axis_tdata), 0);
        end else begin
          want = pending_gains.pop_front();
          if (m_axis_tdata[6:0] !== want.ch)
            report_mismatch("out_channel", m_axis_tdata[6:0], want.ch);
          if (m_axis_tdata[21:7] !== want.level)
            report_mismatch("smoothed_level", m_axis_tdata[21:7], want.level);
          if (m_axis_tdata[53:22] !== want.gain)
            report_mismatch("linear_gain", m_axis_tdata[53:22], want.gain);
        end
      end
      if (recv_stall > 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        recv_stall    <= pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Writes one register once the block takes the transaction.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LEVEL_OFFSET:   sh_level_offset = val;
      CFG_ATTACK_COEF:    sh_attack       = val;
      CFG_RELEASE_COEF:   sh_release      = val;
      CFG_KNEE_LOW:       sh_knee_low     = val[14:0];
      CFG_KNEE_HIGH:      sh_knee_high    = val[14:0];
      CFG_OUTPUT_CEILING: sh_ceiling      = val[14:0];
      default: ;
    endcase
  endtask

  // Waits until every transaction has gone in and every result has come out.
  task automatic wait_idle();
    while (bin_queue.size() != 0 || s_axis_tvalid || pending_gains.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic void add_load(int ch, logic [15:0] lo, logic [15:0] ms,
                                   logic [15:0] mo, logic [15:0] hs, logic [15:0] ho);
    bin_item_t it;
    it = '{OP_LOAD, ch[6:0], $urandom(), lo, ms, mo, hs, ho};
    bin_queue.push_back(it);
    n_load++;
    if (!is_loaded[ch]) begin
      is_loaded[ch] = 1'b1;
      loaded_chans.push_back(ch);
    end
  endfunction

  function automatic void add_process(int ch, logic [31:0] p);
    bin_item_t it;
    it = '{OP_PROCESS, ch[6:0], p, 16'($urandom()), 16'($urandom()), 16'($urandom()),
           16'($urandom()), 16'($urandom())};
    bin_queue.push_back(it);
    n_process++;
  endfunction

  // Power spread over the whole dB range, with occasional zero and full-scale bins.
  function automatic logic [31:0] rand_power();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom() >> $urandom_range(31);
  endfunction

  logic [15:0] settings[PHASES][6] = '{
    '{16'h0000, 16'd32768, 16'd62259, 16'd10240, 16'd16640, 16'd30720},
    '{16'h8000, 16'd0,     16'd65535, 16'd0,     16'd32767, 16'd32767},
    '{16'h7FFF, 16'd65535, 16'd0,     16'd32767, 16'd0,     16'd0},
    '{16'h1400, 16'd4000,  16'd60000, 16'd6000,  16'd3000,  16'd20000},
    '{16'hF000, 16'd50000, 16'd20000, 16'd2000,  16'd9000,  16'd12000},
    '{16'h0A00, 16'd16384, 16'd49152, 16'd8000,  16'd12000, 16'd32767},
    '{16'hFC00, 16'd1,     16'd65534, 16'd5000,  16'd5000,  16'd25000}
  };

  initial begin
    int ch;
    for (int i = 0; i < NUM_CH; i++) begin
      sh_level[i] = '0;
      is_loaded[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      quiet_phase = (ph == 3);
      for (int r = 0; r < 6; r++) write_reg(cfg_idx_e'(r), settings[ph][r]);

      if (ph == 0) begin
        // Coefficient extremes and power corner cases.
        add_load(0,   16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        add_load(127, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        add_load(1,   16'h0000, 16'h1000, 16'h0000, 16'h0800, 16'h0400);
        add_load(2,   16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_process(0,   32'd0);
        add_process(0,   32'hFFFF_FFFF);
        add_process(0,   32'hFFFF_FFFF);
        add_process(0,   32'd1);
        add_process(127, 32'hFFFF_FFFF);
        add_process(127, 32'h8000_0000);
        add_process(127, 32'd0);
        add_process(1,   32'h0001_0000);
        add_process(1,   32'hFFFF_FFFF);
        add_process(1,   32'h7FFF_FFFF);
        add_process(2,   32'd2);
        add_process(2,   32'hFFFF_FFFF);
        add_process(2,   32'h0000_0003);
        add_process(2,   32'd0);
      end

      // Mostly processing on loaded channels, some reloads and fresh channels.
      for (int n = 0; n < PER_PHASE; n++) begin
        if (loaded_chans.size() == 0 || $urandom_range(99) < 12) begin
          ch = $urandom_range(NUM_CH - 1);
          add_load(ch, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()));
        end else begin
          ch = loaded_chans[$urandom_range(loaded_chans.size() - 1)];
          add_process(ch, rand_power());
        end
      end
      wait_idle();
    end

    $display("Covered %0d process and %0d load transactions, %0d results, over %0d settings.",
             n_process, n_load, n_results, PHASES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
